/* design/trrq_pkg.sv */
// Package for the three-level random ready queue.
// Holds the beat structs, command, status and list codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trrq_pkg;

    localparam int PID_W  = 5;
    localparam int PRIO_W = 7;
    localparam int CFG_W  = 7;

    // command codes
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_SELECT  = 2'd2;

    // status codes
    localparam logic [2:0] ST_CHOSEN    = 3'd0;
    localparam logic [2:0] ST_RETRY     = 3'd1;
    localparam logic [2:0] ST_KEEP      = 3'd2;
    localparam logic [2:0] ST_RUN_NULL  = 3'd3;
    localparam logic [2:0] ST_ENQUEUED  = 3'd4;
    localparam logic [2:0] ST_REFUSED   = 3'd5;
    localparam logic [2:0] ST_REMOVED   = 3'd6;
    localparam logic [2:0] ST_NOT_FOUND = 3'd7;

    // list codes
    localparam logic [1:0] LIST_HIGH = 2'd0;
    localparam logic [1:0] LIST_MED  = 2'd1;
    localparam logic [1:0] LIST_LOW  = 2'd2;
    localparam int LIST_COUNT = 3;

    // configuration register indexes
    localparam logic [1:0] REG_MEDIUM_FLOOR      = 2'd0;
    localparam logic [1:0] REG_HIGH_FLOOR        = 2'd1;
    localparam logic [1:0] REG_HIGH_DRAW_LIMIT   = 2'd2;
    localparam logic [1:0] REG_MEDIUM_DRAW_LIMIT = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [PID_W-1:0]  proc_id;
        logic [PRIO_W-1:0] priority_req;
        logic [6:0]        draw_value;
        logic              current_running;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]       status;
        logic [PID_W-1:0] chosen_id;
    } t_out_beat;

    // one command handed to the list store, lists already chosen
    typedef struct packed {
        logic             valid;
        logic [1:0]       command;
        logic [PID_W-1:0] proc_id;
        logic [1:0]       prio_list;
        logic [1:0]       draw_list;
        logic             running;
    } t_lst_req;

endpackage : trrq_pkg

`default_nettype wire

/* design/trrq_lists.sv */
// List store: per-process links, per-list head and tail, and the result register.
// Depends on trrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trrq_lists #(
    parameter int PROC_COUNT = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire trrq_pkg::t_lst_req  i_req,
    output logic                     o_done,
    output trrq_pkg::t_out_beat      o_rsp
);
    import trrq_pkg::*;

    localparam int LW = $clog2(PROC_COUNT + 1);
    localparam int IW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
    localparam logic [LW-1:0] SENT = LW'(PROC_COUNT);

    logic [LW-1:0] r_nxt [PROC_COUNT];
    logic [LW-1:0] r_prv [PROC_COUNT];
    logic [1:0]    r_list [PROC_COUNT];
    logic [PROC_COUNT-1:0] r_valid, n_valid;
    logic [LW-1:0] r_head [LIST_COUNT];
    logic [LW-1:0] r_tail [LIST_COUNT];
    logic [LW-1:0] n_head [LIST_COUNT];
    logic [LW-1:0] n_tail [LIST_COUNT];
    logic          r_done, n_done;
    t_out_beat     r_rsp, n_rsp;

    logic          pid_ok;
    logic [LW-1:0] pid_node;
    logic [1:0]    op_list;
    logic [LW-1:0] node;
    logic [LW-1:0] lnk_a, lnk_b, last;
    logic          do_app, do_rem;
    logic          all_empty;
    logic          nxt_we, prv_we;
    logic [LW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;

    always_comb begin
        pid_ok    = (i_req.proc_id != '0) && (int'(i_req.proc_id) < PROC_COUNT);
        pid_node  = LW'(i_req.proc_id);
        op_list   = (i_req.command == CMD_SELECT) ? i_req.draw_list : i_req.prio_list;
        all_empty = (r_head[0] == SENT) && (r_head[1] == SENT) && (r_head[2] == SENT);
        node      = (i_req.command == CMD_SELECT) ? r_head[op_list] : pid_node;
        // a head or tail node takes the sentinel as its neighbor on that side
        lnk_a     = (node == r_head[op_list]) ? SENT : r_prv[node[IW-1:0]];
        lnk_b     = (node == r_tail[op_list]) ? SENT : r_nxt[node[IW-1:0]];
        last      = r_tail[op_list];

        do_app  = 1'b0;
        do_rem  = 1'b0;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        if (i_req.valid) begin
            case (i_req.command)
                CMD_ENQUEUE: begin
                    n_done = 1'b1;
                    n_rsp.chosen_id = i_req.proc_id;
                    if (pid_ok && !r_valid[pid_node[IW-1:0]]) begin
                        do_app = 1'b1;
                        n_rsp.status = ST_ENQUEUED;
                    end else begin
                        n_rsp.status = ST_REFUSED;
                    end
                end
                CMD_REMOVE: begin
                    n_done = 1'b1;
                    n_rsp.chosen_id = i_req.proc_id;
                    if (pid_ok && r_valid[pid_node[IW-1:0]]
                        && r_list[pid_node[IW-1:0]] == op_list) begin
                        do_rem = 1'b1;
                        n_rsp.status = ST_REMOVED;
                    end else begin
                        n_rsp.status = ST_NOT_FOUND;
                    end
                end
                CMD_SELECT: begin
                    n_done = 1'b1;
                    n_rsp.chosen_id = '0;
                    if (all_empty) begin
                        n_rsp.status = i_req.running ? ST_KEEP : ST_RUN_NULL;
                    end else if (r_head[op_list] == SENT) begin
                        n_rsp.status = ST_RETRY;
                    end else begin
                        do_rem = 1'b1;
                        n_rsp.status = ST_CHOSEN;
                        n_rsp.chosen_id = PID_W'(node);
                    end
                end
                default: begin
                end
            endcase
        end

        n_valid = r_valid;
        for (int l = 0; l < LIST_COUNT; l++) begin
            n_head[l] = r_head[l];
            n_tail[l] = r_tail[l];
        end
        nxt_we = 1'b0;
        prv_we = 1'b0;
        nxt_wa = lnk_a;
        nxt_wd = lnk_b;
        prv_wa = lnk_b;
        prv_wd = lnk_a;
        if (do_rem) begin
            // unlink: splice the neighbors together
            n_valid[node[IW-1:0]] = 1'b0;
            if (lnk_a == SENT) n_head[op_list] = lnk_b;
            else               nxt_we = 1'b1;
            if (lnk_b == SENT) n_tail[op_list] = lnk_a;
            else               prv_we = 1'b1;
        end else if (do_app) begin
            // append after the current tail
            n_valid[node[IW-1:0]] = 1'b1;
            n_tail[op_list] = node;
            prv_we = 1'b1;
            prv_wa = node;
            prv_wd = last;
            if (last == SENT) begin
                n_head[op_list] = node;
            end else begin
                nxt_we = 1'b1;
                nxt_wa = last;
                nxt_wd = node;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
            for (int l = 0; l < LIST_COUNT; l++) begin
                r_head[l] <= SENT;
                r_tail[l] <= SENT;
            end
        end else begin
            r_valid <= n_valid;
            r_done  <= n_done;
            for (int l = 0; l < LIST_COUNT; l++) begin
                r_head[l] <= n_head[l];
                r_tail[l] <= n_tail[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (nxt_we) r_nxt[nxt_wa[IW-1:0]] <= nxt_wd;
        if (prv_we) r_prv[prv_wa[IW-1:0]] <= prv_wd;
        if (do_app) r_list[node[IW-1:0]] <= op_list;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule : trrq_lists

`default_nettype wire

/* design/three_level_random_ready_queue.sv */
// Top level of the three-level random ready queue.
// Holds the APB registers, the command register and the list choice.
// Depends on trrq_pkg and trrq_lists.
//
//   channel   | signals                         | handshake
//   ----------+---------------------------------+------------------------------
//   command   | i_start, o_busy, i_req          | beat taken when start & !busy
//   result    | o_done, o_rsp                   | one-cycle strobe, no stall
//   config    | psel penable pwrite paddr       | write at access with pready
//             | pwdata prdata pready            |
//
// A command's result passes from the command register, which feeds the list store's
// link logic, into the result register. A new command is accepted every cycle; o_busy
// stays low.
// Reset empties all three lists at once (head and tail registers plus valid
// bits), so no clearing pass is needed. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module three_level_random_ready_queue #(
    parameter int PROC_COUNT = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire trrq_pkg::t_in_beat  i_req,
    output logic                     o_done,
    output trrq_pkg::t_out_beat      o_rsp,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import trrq_pkg::*;

    logic [CFG_W-1:0] r_medium_floor, r_high_floor;
    logic [CFG_W-1:0] r_high_draw_limit, r_medium_draw_limit;
    logic             cfg_wr;

    logic             r_cmd_vld;
    t_in_beat         r_cmd;
    t_lst_req         lst_req;

    assign pready = 1'b1;
    assign o_busy = 1'b0;
    assign cfg_wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_medium_floor      <= CFG_W'(33);
            r_high_floor        <= CFG_W'(63);
            r_high_draw_limit   <= CFG_W'(70);
            r_medium_draw_limit <= CFG_W'(90);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MEDIUM_FLOOR:      r_medium_floor      <= pwdata[CFG_W-1:0];
                REG_HIGH_FLOOR:        r_high_floor        <= pwdata[CFG_W-1:0];
                REG_HIGH_DRAW_LIMIT:   r_high_draw_limit   <= pwdata[CFG_W-1:0];
                REG_MEDIUM_DRAW_LIMIT: r_medium_draw_limit <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_MEDIUM_FLOOR:      prdata[CFG_W-1:0] = r_medium_floor;
            REG_HIGH_FLOOR:        prdata[CFG_W-1:0] = r_high_floor;
            REG_HIGH_DRAW_LIMIT:   prdata[CFG_W-1:0] = r_high_draw_limit;
            REG_MEDIUM_DRAW_LIMIT: prdata[CFG_W-1:0] = r_medium_draw_limit;
            default: prdata = '0;
        endcase
    end

    // register that a command beat was accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else begin
            r_cmd_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) r_cmd <= i_req;
    end

    // choose lists: high floor wins when the floors cross
    always_comb begin
        lst_req.valid   = r_cmd_vld;
        lst_req.command = r_cmd.command;
        lst_req.proc_id = r_cmd.proc_id;
        lst_req.running = r_cmd.current_running;
        if (r_cmd.priority_req >= r_high_floor)        lst_req.prio_list = LIST_HIGH;
        else if (r_cmd.priority_req >= r_medium_floor) lst_req.prio_list = LIST_MED;
        else                                           lst_req.prio_list = LIST_LOW;
        if (r_cmd.draw_value < r_high_draw_limit)        lst_req.draw_list = LIST_HIGH;
        else if (r_cmd.draw_value < r_medium_draw_limit) lst_req.draw_list = LIST_MED;
        else                                             lst_req.draw_list = LIST_LOW;
    end

    trrq_lists #(
        .PROC_COUNT(PROC_COUNT)
    ) u_lists (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lst_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule : three_level_random_ready_queue

`default_nettype wire
